// ===== hw/rtl/dnle_pkg.sv =====
// Package for the DNS name label encoder.
// Holds label store sizing, the label separator code and the cell control struct.
// No dependencies.
package dnle_pkg;

  localparam int MAX_LABEL = 32;
  localparam int CNT_W     = $clog2(MAX_LABEL + 1);

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  // Shift controls broadcast to every cell of the label chain
  typedef struct packed {
    logic wr;   // append one character at the first free cell
    logic rd;   // shift every cell one place toward the head
  } cell_ctl_t;

endpackage

// ===== hw/rtl/dnle_if.sv =====
// Valid/ready channel interfaces of the DNS name label encoder.
// Depends on nothing; payload widths follow the encoder's item fields.
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       name_end;

  modport source (output valid, output ch, output name_end, input ready);
  modport sink   (input valid, input ch, input name_end, output ready);
endinterface

interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       name_done;
  logic       overflow;

  modport source (output valid, output out_byte, output run_last, output name_done,
                  output overflow, input ready);
  modport sink   (input valid, input out_byte, input run_last, input name_done,
                  input overflow, output ready);
endinterface

// ===== hw/rtl/dnle_cell.sv =====
// One cell of the label chain: a character byte and its occupied flag.
// Depends on dnle_pkg for the control struct.
module dnle_cell
  import dnle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic [7:0] wr_data,
  input  logic       prev_occ,
  input  logic [7:0] next_data,
  input  logic       next_occ,
  output logic [7:0] data,
  output logic       occ
);

  logic [7:0] data_r;
  logic       occ_r;
  logic       take_wr;

  // Claim the write when this is the first free cell
  assign take_wr = ctl.wr && !occ_r && prev_occ;

  // Occupied flag: set on append, follow the neighbor on a shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl.rd) begin
      occ_r <= next_occ;
    end else if (take_wr) begin
      occ_r <= 1'b1;
    end
  end

  // Character byte: load on append, take the neighbor's byte on a shift
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      data_r <= next_data;
    end else if (take_wr) begin
      data_r <= wr_data;
    end
  end

  assign data = data_r;
  assign occ  = occ_r;

endmodule

// ===== hw/rtl/dnle_chain.sv =====
// Label store built as a row of dnle_cell instances; reads come off the head cell.
// Depends on dnle_pkg and dnle_cell.
module dnle_chain
  import dnle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [7:0]           wr_data,
  output logic [7:0]           head_data,
  output logic [MAX_LABEL-1:0] occ
);

  logic [7:0] data_a [MAX_LABEL];
  logic [7:0] nxt_data_a [MAX_LABEL];
  logic [MAX_LABEL-1:0] prev_occ;
  logic [MAX_LABEL-1:0] nxt_occ;

  // Wire each cell to its neighbors; the ends see a full head and an empty tail
  genvar gi;
  generate
    for (gi = 0; gi < MAX_LABEL; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_occ[gi] = 1'b1;
      end else begin : g_body
        assign prev_occ[gi] = occ[gi-1];
      end
      if (gi == MAX_LABEL - 1) begin : g_tail
        assign nxt_data_a[gi] = ZERO_BYTE;
        assign nxt_occ[gi]    = 1'b0;
      end else begin : g_link
        assign nxt_data_a[gi] = data_a[gi+1];
        assign nxt_occ[gi]    = occ[gi+1];
      end

      dnle_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .wr_data   (wr_data),
        .prev_occ  (prev_occ[gi]),
        .next_data (nxt_data_a[gi]),
        .next_occ  (nxt_occ[gi]),
        .data      (data_a[gi]),
        .occ       (occ[gi])
      );
    end
  endgenerate

  assign head_data = data_a[0];

endmodule

// ===== hw/rtl/dns_name_label_encoder_unit.sv =====
// Top level of the DNS name label encoder: sequencer, label counter and output register.
// Depends on dnle_pkg, dnle_if and dnle_chain.
//
//  channel  | dir | interface   | payload
//  in_chan  | in  | dnle_in_if  | ch[7:0], name_end
//  out_chan | out | dnle_out_if | out_byte[7:0], run_last, name_done, overflow
//
// A character other than '.' that does not end the name gives no result. A label
// is sent as one byte a cycle while the output is not stalled: length byte, then the
// label bytes shifted off the head of the cell chain, then the zero terminator
// when the name ends. Input is taken only while the sequencer is idle; a stalled
// output holds the output register and the sequencer. A synchronous reset empties
// the chain.
module dns_name_label_encoder_unit
  import dnle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  dnle_in_if.sink           in_chan,
  dnle_out_if.source        out_chan
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LEN  = 4'b0010,
    S_DATA = 4'b0100,
    S_TERM = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                run_last_r, run_last_nxt;
  logic                done_r, done_nxt;
  logic                ovf_out_r, ovf_out_nxt;

  logic                in_acc;
  logic                emit;
  logic                is_dot;
  logic                full;
  cell_ctl_t           ctl;
  logic [7:0]          head_data;
  logic [MAX_LABEL-1:0] occ;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign is_dot        = (in_chan.ch == DOT_CHAR);
  assign full          = (count_r == CNT_W'(MAX_LABEL));
  assign emit          = (state_r != S_IDLE) && (!out_valid_r || out_chan.ready);

  dnle_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .wr_data   (in_chan.ch),
    .head_data (head_data),
    .occ       (occ)
  );

  // Sequence: hold characters, then send length, label bytes and, at name end, terminator
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    last_nxt     = last_r;
    ctl          = '{wr: 1'b0, rd: 1'b0};
    out_byte_nxt = out_byte_r;
    run_last_nxt = run_last_r;
    done_nxt     = done_r;
    ovf_out_nxt  = ovf_out_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_dot) begin
            if (!full) begin
              ctl.wr    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (is_dot || in_chan.name_end) begin
            last_nxt  = in_chan.name_end;
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (emit) begin
          out_byte_nxt = 8'(count_r);
          run_last_nxt = (count_r == '0) && !last_r;
          done_nxt     = 1'b0;
          ovf_out_nxt  = ovf_r;
          if (count_r != '0) begin
            state_nxt = S_DATA;
          end else if (last_r) begin
            state_nxt = S_TERM;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DATA: begin
        if (emit) begin
          ctl.rd       = 1'b1;
          count_nxt    = count_r - CNT_W'(1);
          out_byte_nxt = head_data;
          run_last_nxt = (count_r == CNT_W'(1)) && !last_r;
          done_nxt     = 1'b0;
          ovf_out_nxt  = ovf_r;
          if (count_r == CNT_W'(1)) begin
            state_nxt = last_r ? S_TERM : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (emit) begin
          out_byte_nxt = ZERO_BYTE;
          run_last_nxt = 1'b1;
          done_nxt     = 1'b1;
          ovf_out_nxt  = ovf_r;
          ovf_nxt      = 1'b0;
          count_nxt    = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold a result until the sink takes it
  assign out_valid_nxt = emit || (out_valid_r && !out_chan.ready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    run_last_r <= run_last_nxt;
    done_r     <= done_nxt;
    ovf_out_r  <= ovf_out_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_byte  = out_byte_r;
  assign out_chan.run_last  = run_last_r;
  assign out_chan.name_done = done_r;
  assign out_chan.overflow  = ovf_out_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_LABEL))
    else $error("label count beyond store capacity");

  a_chain_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ) == int'(count_r))
    else $error("cell chain occupancy differs from label count");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == S_TERM) |=> (!ovf_r && count_r == '0 && state_r == S_IDLE))
    else $error("name end did not clear label state");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (run_last_r && out_byte_r == ZERO_BYTE))
    else $error("terminator not marked as last result");
`endif

endmodule
